// ----- rtl/nvpd_pkg.sv -----
package nvpd_pkg;

  // Width of a decoded name or value length.
  localparam int LEN_W = 31;
  // Width of the max_size register.
  localparam int SIZE_W = 32;

  localparam logic [SIZE_W-1:0] MAX_SIZE_RESET = 32'd65535;
  // Further bytes that follow the first byte of a four-byte length.
  localparam logic [1:0] LONG_EXTRA_BYTES = 2'd3;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_NAME   = 2'd1,
    KIND_VALUE  = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_NAME_LEN0 = 3'd0,
    PH_NAME_LEN  = 3'd1,
    PH_VAL_LEN0  = 3'd2,
    PH_VAL_LEN   = 3'd3,
    PH_NAME      = 3'd4,
    PH_VALUE     = 3'd5
  } phase_t;

endpackage

// ----- rtl/name_value_pair_deframer.sv -----
// Name-value pair deframer. It takes a stream of back-to-back name-value
// pairs, one raw byte per input item, and accepts one item in every clock
// cycle as long as the result side keeps up. Each pair opens with a name
// length and a value length; a length is one byte when its top bit is clear,
// and four big-endian bytes with that top bit masked off otherwise. Length
// bytes produce no result, except the byte that completes the value length:
// it produces a header result carrying both lengths, or a size error result
// when their exact sum exceeds max_size. After a size error the next byte is
// taken as the first name length byte of a new pair. After a header, each
// name byte and then each value byte comes out as its own result. The last
// result of a pair has last_of_pair set; a pair with both lengths zero ends
// on its header. Each item passes from the input through one stage of
// decode logic into the output register, so a result appears in the cycle
// after its byte is accepted, and the input stays ready while that
// register is empty or being emptied in the same cycle. The update of the
// pair state and the length sum compare in the value length phase set the
// clock period. max_size resets to 65535 and should only be written while
// the block is idle; the configuration port is always ready.
module name_value_pair_deframer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nvpd_pkg::SIZE_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output nvpd_pkg::kind_t                     kind,
  output logic [7:0]                          data_byte,
  output logic [nvpd_pkg::LEN_W-1:0]          name_length,
  output logic [nvpd_pkg::LEN_W-1:0]          value_length,
  output logic                                last_of_pair
);
  import nvpd_pkg::*;

  // Configuration.
  logic [SIZE_W-1:0] max_size;

  // Pair state.
  phase_t            phase, phase_next;
  logic [1:0]        length_byte_count, length_byte_count_next;
  logic [LEN_W-1:0]  held_name_length, held_name_length_next;
  logic [LEN_W-1:0]  held_value_length, held_value_length_next;
  logic [LEN_W-1:0]  bytes_remaining, bytes_remaining_next;

  // Result of the item at the input, before the output register.
  logic              res_valid;
  kind_t             res_kind;
  logic [7:0]        res_data;
  logic [LEN_W-1:0]  res_name_length;
  logic [LEN_W-1:0]  res_value_length;
  logic              res_last;

  logic              in_fire;
  logic              is_long;
  logic              finishing;
  logic [LEN_W-1:0]  name_shifted;
  logic [LEN_W-1:0]  value_shifted;
  logic [LEN_W-1:0]  final_value_length;
  logic [SIZE_W-1:0] length_sum;
  logic              too_big;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign is_long   = in_byte[7];

  assign name_shifted  = {held_name_length[LEN_W-9:0], in_byte};
  assign value_shifted = {held_value_length[LEN_W-9:0], in_byte};

  // The byte that completes the value length: a short first byte, or the
  // last of the three further bytes of a long length.
  assign finishing = ((phase == PH_VAL_LEN0) && !is_long) ||
                     ((phase == PH_VAL_LEN) && (length_byte_count == 2'd1));
  assign final_value_length = (phase == PH_VAL_LEN0) ?
                              {{(LEN_W-8){1'b0}}, in_byte} : value_shifted;

  // Both lengths are 31 bits, so their sum always fits in 32 bits.
  assign length_sum = {1'b0, held_name_length} + {1'b0, final_value_length};
  assign too_big    = length_sum > max_size;

  // Next state of the pair decoder.
  always_comb begin
    phase_next             = phase;
    length_byte_count_next = length_byte_count;
    held_name_length_next  = held_name_length;
    held_value_length_next = held_value_length;
    bytes_remaining_next   = bytes_remaining;
    unique case (phase)
      PH_NAME_LEN: begin
        held_name_length_next  = name_shifted;
        length_byte_count_next = length_byte_count - 2'd1;
        if (length_byte_count == 2'd1) begin
          phase_next = PH_VAL_LEN0;
        end
      end
      PH_VAL_LEN0, PH_VAL_LEN: begin
        if ((phase == PH_VAL_LEN0) && is_long) begin
          held_value_length_next = {{(LEN_W-7){1'b0}}, in_byte[6:0]};
          length_byte_count_next = LONG_EXTRA_BYTES;
          phase_next             = PH_VAL_LEN;
        end else begin
          held_value_length_next = final_value_length;
          if (phase == PH_VAL_LEN) begin
            length_byte_count_next = length_byte_count - 2'd1;
          end
          if (finishing) begin
            priority if (too_big) begin
              phase_next           = PH_NAME_LEN0;
              bytes_remaining_next = '0;
            end else if (held_name_length != '0) begin
              phase_next           = PH_NAME;
              bytes_remaining_next = held_name_length;
            end else if (final_value_length != '0) begin
              phase_next           = PH_VALUE;
              bytes_remaining_next = final_value_length;
            end else begin
              phase_next           = PH_NAME_LEN0;
              bytes_remaining_next = '0;
            end
          end
        end
      end
      PH_NAME: begin
        bytes_remaining_next = bytes_remaining - {{(LEN_W-1){1'b0}}, 1'b1};
        if (bytes_remaining == {{(LEN_W-1){1'b0}}, 1'b1}) begin
          if (held_value_length != '0) begin
            phase_next           = PH_VALUE;
            bytes_remaining_next = held_value_length;
          end else begin
            phase_next = PH_NAME_LEN0;
          end
        end
      end
      PH_VALUE: begin
        bytes_remaining_next = bytes_remaining - {{(LEN_W-1){1'b0}}, 1'b1};
        if (bytes_remaining == {{(LEN_W-1){1'b0}}, 1'b1}) begin
          phase_next = PH_NAME_LEN0;
        end
      end
      default: begin
        // First name length byte; unused codes behave the same way.
        held_value_length_next = '0;
        bytes_remaining_next   = '0;
        if (is_long) begin
          held_name_length_next  = {{(LEN_W-7){1'b0}}, in_byte[6:0]};
          length_byte_count_next = LONG_EXTRA_BYTES;
          phase_next             = PH_NAME_LEN;
        end else begin
          held_name_length_next  = {{(LEN_W-8){1'b0}}, in_byte};
          length_byte_count_next = 2'd0;
          phase_next             = PH_VAL_LEN0;
        end
      end
    endcase
  end

  // Result produced by the byte at the input.
  always_comb begin
    res_valid        = 1'b0;
    res_kind         = KIND_HEADER;
    res_data         = 8'd0;
    res_name_length  = '0;
    res_value_length = '0;
    res_last         = 1'b0;
    unique case (phase)
      PH_VAL_LEN0, PH_VAL_LEN: begin
        res_valid        = finishing;
        res_kind         = too_big ? KIND_ERROR : KIND_HEADER;
        res_name_length  = held_name_length;
        res_value_length = final_value_length;
        res_last         = too_big || (length_sum == '0);
      end
      PH_NAME: begin
        res_valid = 1'b1;
        res_kind  = KIND_NAME;
        res_data  = in_byte;
        res_last  = (bytes_remaining == {{(LEN_W-1){1'b0}}, 1'b1}) &&
                    (held_value_length == '0);
      end
      PH_VALUE: begin
        res_valid = 1'b1;
        res_kind  = KIND_VALUE;
        res_data  = in_byte;
        res_last  = (bytes_remaining == {{(LEN_W-1){1'b0}}, 1'b1});
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_size <= MAX_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_size <= cfg_data;
    end
  end

  // Pair state advances once per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_NAME_LEN0;
      length_byte_count <= 2'd0;
      held_name_length  <= '0;
      held_value_length <= '0;
      bytes_remaining   <= '0;
    end else if (in_fire) begin
      phase             <= phase_next;
      length_byte_count <= length_byte_count_next;
      held_name_length  <= held_name_length_next;
      held_value_length <= held_value_length_next;
      bytes_remaining   <= bytes_remaining_next;
    end
  end

  // Output register: refilled whenever it is empty or being taken, so the
  // input never waits on a result that is already on its way out.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      kind         <= res_kind;
      data_byte    <= res_data;
      name_length  <= res_name_length;
      value_length <= res_value_length;
      last_of_pair <= res_last;
    end
  end

endmodule
